/* rtl/core/utv_pkg.sv */
// utv_pkg: shared widths, character codes and the field snapshot struct
// for the UTC timestamp validator. No dependencies.
`timescale 1ns / 1ps

package utv_pkg;

  // Character and field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned FieldW  = 7;

  // Fixed string geometry: position 20 means exactly 20 chars seen,
  // 21 means more than that (the counter saturates there)
  localparam logic [PosW-1:0] TsLength = PosW'(20);
  localparam logic [PosW-1:0] PosSat   = PosW'(21);

  // Separator characters
  localparam logic [CharW-1:0] ChDash  = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChT     = 8'h54;  // 'T'
  localparam logic [CharW-1:0] ChColon = 8'h3A;  // ':'
  localparam logic [CharW-1:0] ChZ     = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'

  // Range limits
  localparam logic [FieldW-1:0] MaxMonth  = FieldW'(12);
  localparam logic [FieldW-1:0] MaxHour   = FieldW'(23);
  localparam logic [FieldW-1:0] MaxMinSec = FieldW'(59);
  localparam logic [FieldW-1:0] LeapFeb   = FieldW'(29);
  localparam logic [FieldW-1:0] MonthFeb  = FieldW'(2);

  // Snapshot of the parse state including the current character.
  // The year is kept as century (first two digits) and year-of-century.
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic              error;
    logic [FieldW-1:0] cent;
    logic [FieldW-1:0] yy;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } utv_fields_t;

endpackage

/* rtl/core/utv_char_if.sv */
// utv_char_if, utv_result_if: valid/ready channels for input characters and
// for the verdict word. Depends on utv_pkg.
`timescale 1ns / 1ps

interface utv_char_if;
  logic                       valid;
  logic                       ready;
  logic [utv_pkg::CharW-1:0]  char_code;
  logic                       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface utv_result_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

/* rtl/core/utc_timestamp_validator.sv */
// utc_timestamp_validator: top level; input register, parser and judge.
// Depends on utv_pkg, utv_char_if/utv_result_if, utv_parse, utv_judge.
//
//   channel  dir  payload                    words
//   char_i   in   char_code[7:0], last_char  one per string character
//   res_o    out  is_valid                   one per string (on last_char)
//
// One character is accepted per cycle, except while a last character waits
// in the input register for the output register to be free. A character
// updates the parse state from the input register; a last character writes
// its verdict to the output register, and the word leaves from there.
// Reset clears valid flags and parse state; the next character starts a new string.
// Stalls on res_o hold back only last characters and the ones behind them.
`timescale 1ns / 1ps

module utc_timestamp_validator (
  input  logic          clk_i,
  input  logic          rst_ni,
  utv_char_if.sink      char_i,
  utv_result_if.source  res_o
);
  import utv_pkg::*;

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_last_q;
  logic              in_advance;
  logic              out_free;
  utv_fields_t       fields;

  // A character moves on unless it is last and the output is still full
  assign in_advance   = in_valid_q && (!in_last_q || out_free);
  assign char_i.ready = !in_valid_q || in_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      in_char_q <= char_i.char_code;
      in_last_q <= char_i.last_char;
    end
  end

  utv_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .commit_i (in_advance),
    .fields_o (fields)
  );

  utv_judge u_judge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fields_i (fields),
    .load_i   (in_advance && in_last_q),
    .free_o   (out_free),
    .res_o    (res_o)
  );

endmodule

/* rtl/core/utv_parse.sv */
// utv_parse: position counter, format error flag and decimal field
// accumulators, advanced one character per commit. Depends on utv_pkg.
`timescale 1ns / 1ps

module utv_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [utv_pkg::CharW-1:0]  char_i,
  input  logic                       last_i,
  input  logic                       commit_i,
  output utv_pkg::utv_fields_t       fields_o
);
  import utv_pkg::*;

  typedef enum logic [2:0] {
    ROLE_SEP, ROLE_CENT, ROLE_YY, ROLE_MONTH, ROLE_DAY, ROLE_HOUR, ROLE_MIN, ROLE_SEC
  } role_e;

  utv_fields_t       fields_q, fields_d;
  role_e             role;
  logic [CharW-1:0]  sep_char;
  logic              is_digit;
  logic              char_bad;
  logic [3:0]        digit;

  // Role of each position within YYYY-MM-DDTHH:MM:SSZ
  always_comb begin
    role     = ROLE_SEP;
    sep_char = ChZ;
    unique case (fields_q.pos)
      5'd0, 5'd1:   role = ROLE_CENT;
      5'd2, 5'd3:   role = ROLE_YY;
      5'd4, 5'd7:   sep_char = ChDash;
      5'd5, 5'd6:   role = ROLE_MONTH;
      5'd8, 5'd9:   role = ROLE_DAY;
      5'd10:        sep_char = ChT;
      5'd11, 5'd12: role = ROLE_HOUR;
      5'd13, 5'd16: sep_char = ChColon;
      5'd14, 5'd15: role = ROLE_MIN;
      5'd17, 5'd18: role = ROLE_SEC;
      default:      sep_char = ChZ;
    endcase
  end

  function automatic logic [FieldW-1:0] add_digit(logic [FieldW-1:0] acc, logic [3:0] d);
    logic [FieldW+3:0] sum;
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{FieldW{1'b0}}, d};
    return sum[FieldW-1:0];
  endfunction

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign digit    = char_i[3:0];
  assign char_bad = (role == ROLE_SEP) ? (char_i != sep_char) : !is_digit;

  // Next snapshot; positions past the end are not examined
  always_comb begin
    fields_d = fields_q;
    if (fields_q.pos != PosSat) begin
      fields_d.pos = fields_q.pos + PosW'(1);
    end
    if (fields_q.pos < TsLength) begin
      if (char_bad) begin
        fields_d.error = 1'b1;
      end else begin
        case (role)
          ROLE_CENT:  fields_d.cent   = add_digit(fields_q.cent, digit);
          ROLE_YY:    fields_d.yy     = add_digit(fields_q.yy, digit);
          ROLE_MONTH: fields_d.month  = add_digit(fields_q.month, digit);
          ROLE_DAY:   fields_d.day    = add_digit(fields_q.day, digit);
          ROLE_HOUR:  fields_d.hour   = add_digit(fields_q.hour, digit);
          ROLE_MIN:   fields_d.minute = add_digit(fields_q.minute, digit);
          ROLE_SEC:   fields_d.second = add_digit(fields_q.second, digit);
          default:    fields_d.error  = fields_q.error;
        endcase
      end
    end
  end

  // State: cleared after the last character of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
    end else if (commit_i) begin
      fields_q <= last_i ? '0 : fields_d;
    end
  end

  assign fields_o = fields_d;

endmodule

/* rtl/core/utv_judge.sv */
// utv_judge: range and calendar checks on a finished field snapshot, and
// the output word register. Depends on utv_pkg and utv_result_if.
`timescale 1ns / 1ps

module utv_judge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utv_pkg::utv_fields_t  fields_i,
  input  logic                  load_i,
  output logic                  free_o,
  utv_result_if.source          res_o
);
  import utv_pkg::*;

  logic              out_valid_q;
  logic              verdict_q, verdict_d;
  logic              leap;
  logic              month_ok;
  logic [FieldW-1:0] max_day;

  function automatic logic [FieldW-1:0] month_days(logic [3:0] m);
    logic [FieldW-1:0] days;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: days = FieldW'(30);
      4'd2:                    days = FieldW'(28);
      default:                 days = FieldW'(31);
    endcase
    return days;
  endfunction

  // Gregorian leap year from century and year-of-century
  assign leap = ((fields_i.yy[1:0] == 2'b00) && (fields_i.yy != '0)) ||
                ((fields_i.yy == '0) && (fields_i.cent[1:0] == 2'b00));

  assign month_ok = (fields_i.month != '0) && (fields_i.month <= MaxMonth);

  always_comb begin
    max_day = month_days(fields_i.month[3:0]);
    if ((fields_i.month == MonthFeb) && leap) begin
      max_day = LeapFeb;
    end
  end

  // Overall verdict
  assign verdict_d = (fields_i.pos == TsLength) && !fields_i.error &&
                     ((fields_i.cent != '0) || (fields_i.yy != '0)) && month_ok &&
                     (fields_i.hour <= MaxHour) && (fields_i.minute <= MaxMinSec) &&
                     (fields_i.second <= MaxMinSec) &&
                     (fields_i.day != '0) && (fields_i.day <= max_day);

  assign free_o = !out_valid_q || res_o.ready;

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (free_o) begin
      out_valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      verdict_q <= verdict_d;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.is_valid = verdict_q;

endmodule

/* test/utc_timestamp_validator_tb.sv */
// utc_timestamp_validator_tb: self-checking bench for the UTC timestamp validator.
// Drives characters through utv_char_if, tracks the parse state alongside the
// block and checks every verdict word; depends on utv_pkg and the channel ifs.
`timescale 1ns / 1ps

module utc_timestamp_validator_tb;
  import utv_pkg::*;

  logic clk_i;
  logic rst_ni;

  utv_char_if   char_bus ();
  utv_result_if res_bus ();

  utc_timestamp_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .res_o  (res_bus)
  );

  // Shadow parse state; the year is kept whole in 14 bits, the rest has the block's widths
  logic [PosW-1:0]   seen_len = '0;
  logic              bad_char = 1'b0;
  logic [13:0]       yr       = '0;
  logic [FieldW-1:0] mon      = '0;
  logic [FieldW-1:0] dom      = '0;
  logic [FieldW-1:0] hh       = '0;
  logic [FieldW-1:0] mm       = '0;
  logic [FieldW-1:0] ss       = '0;

  logic              verdicts_due[$];
  logic              want_verdict;
  int                mismatches = 0;

  logic [CharW-1:0]  text[$];
  int                burst_left = 0;
  int                rx_cycle   = 0;
  int                rx_mode    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // Separator required at a position, zero where a digit belongs
  function automatic logic [CharW-1:0] sep_at(input logic [PosW-1:0] pos);
    case (pos)
      5'd4, 5'd7:   return ChDash;
      5'd10:        return ChT;
      5'd13, 5'd16: return ChColon;
      5'd19:        return ChZ;
      default:      return '0;
    endcase
  endfunction

  function automatic logic [FieldW-1:0] month_length(input logic [FieldW-1:0] m,
                                                    input logic [13:0] y);
    int yi;
    yi = int'(y);
    case (m)
      MonthFeb: begin
        if (((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0)) return LeapFeb;
        return FieldW'(28);
      end
      FieldW'(4), FieldW'(6), FieldW'(9), FieldW'(11): return FieldW'(30);
      default: return FieldW'(31);
    endcase
  endfunction

  function automatic logic timestamp_ok();
    if (seen_len != TsLength || bad_char) return 1'b0;
    if (yr == 0 || mon == 0 || mon > MaxMonth || hh > MaxHour ||
        mm > MaxMinSec || ss > MaxMinSec) return 1'b0;
    return (dom >= 1) && (dom <= month_length(mon, yr));
  endfunction

  // Advance the shadow state by one accepted character
  task automatic track_char(input logic [CharW-1:0] c, input logic last);
    logic [CharW-1:0] sep;
    logic [3:0]       d;
    if (seen_len < TsLength) begin
      sep = sep_at(seen_len);
      if (sep != '0) begin
        if (c != sep) bad_char = 1'b1;
      end else if (c < ChZero || c > ChNine) begin
        bad_char = 1'b1;
      end else begin
        d = 4'(c - ChZero);
        if (seen_len <= 3)       yr  = yr * 14'd10 + 14'(d);
        else if (seen_len <= 6)  mon = mon * 7'd10 + 7'(d);
        else if (seen_len <= 9)  dom = dom * 7'd10 + 7'(d);
        else if (seen_len <= 12) hh  = hh * 7'd10 + 7'(d);
        else if (seen_len <= 15) mm  = mm * 7'd10 + 7'(d);
        else                     ss  = ss * 7'd10 + 7'(d);
      end
    end
    if (seen_len < PosSat) seen_len++;
    // last character: record the verdict and start a fresh string
    if (last) begin
      verdicts_due.push_back(timestamp_ok());
      seen_len = '0;
      bad_char = 1'b0;
      yr = '0; mon = '0; dom = '0; hh = '0; mm = '0; ss = '0;
    end
  endtask

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Send one character word; bursts of random length with random gaps
  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        char_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last_char <= last;
    do @(posedge clk_i); while (!char_bus.ready);
    track_char(c, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // Hold the sender until every verdict is back
  task automatic wait_idle();
    char_bus.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic void put_digits(input int unsigned v, input int n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      text.push_back(ChZero + CharW'((v / div) % 10));
      div /= 10;
    end
  endfunction

  // Well-formed YYYY-MM-DDTHH:MM:SSZ into text
  function automatic void build_timestamp(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
    text.delete();
    put_digits(y, 4);  text.push_back(ChDash);
    put_digits(mo, 2); text.push_back(ChDash);
    put_digits(d, 2);  text.push_back(ChT);
    put_digits(h, 2);  text.push_back(ChColon);
    put_digits(mi, 2); text.push_back(ChColon);
    put_digits(s, 2);  text.push_back(ChZ);
  endfunction

  // Mostly in range, with the edges and some out-of-range values
  function automatic int unsigned pick_field(input int unsigned top);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return top;
      2:       return top + 1;
      3:       return $urandom_range(0, 99);
      default: return $urandom_range(1, top);
    endcase
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 1;
      2:       return 1900;
      3:       return 2000;
      4:       return 2023;
      5:       return 2024;
      6:       return 9999;
      7:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  function automatic int unsigned pick_day();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 4) return 28 + r;
    return pick_field(31);
  endfunction

  function automatic void build_random_timestamp();
    build_timestamp(pick_year(), pick_field(12), pick_day(), pick_field(23),
                    pick_field(59), pick_field(59));
  endfunction

  // Verdict checker
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (verdicts_due.size() == 0) begin
        note_mismatch($sformatf("unexpected verdict is_valid=%0b", res_bus.is_valid));
      end else begin
        want_verdict = verdicts_due.pop_front();
        if (res_bus.is_valid !== want_verdict)
          note_mismatch($sformatf("is_valid expected %0b got %0b",
                                  want_verdict, res_bus.is_valid));
      end
    end
  end

  // Receiver stalls: a pattern picked at random from always ready, random ready and two periodic ones
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= 1'($urandom_range(0, 1));
        2:       res_bus.ready <= (rx_cycle % 5 == 0);
        default: res_bus.ready <= (rx_cycle % 8 >= 6);
      endcase
    end
  end

  // Extreme byte values as one-character strings
  task automatic test_single_char();
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // Largest legal timestamp
  task automatic test_max_timestamp();
    build_timestamp(9999, 12, 31, 23, 59, 59);
    send_text();
  endtask

  // Well-formed strings with random calendar content
  task automatic test_calendar();
    // leap-year rules first: 400-year rule, century rule, plain 4-year rule
    build_timestamp(2000, 2, 29, 0, 0, 0);   send_text();
    build_timestamp(1900, 2, 29, 12, 30, 30); send_text();
    build_timestamp(2023, 2, 29, 1, 1, 1);   send_text();
    build_timestamp(2024, 2, 29, 23, 59, 59); send_text();
    repeat (28) begin
      build_random_timestamp();
      send_text();
    end
  endtask

  // One bad byte in an otherwise well-formed string, plus pure noise
  task automatic test_corrupted();
    int k;
    repeat (16) begin
      build_random_timestamp();
      k = $urandom_range(0, 19);
      case ($urandom_range(0, 4))
        0: text[k] = CharW'($urandom_range(0, 255));
        1: text[k] = ChZero - 8'd1;
        2: text[k] = ChNine + 8'd1;
        3: text[k] = (sep_at(PosW'(k)) != '0) ? ChZero + CharW'($urandom_range(0, 9))
                                              : ChDash;
        default: foreach (text[i]) text[i] = CharW'($urandom_range(0, 255));
      endcase
      send_text();
    end
  endtask

  // Short and long strings, including counter saturation
  task automatic test_lengths();
    int sent;
    int len;
    sent = 0;
    while (sent < 260) begin
      build_random_timestamp();
      case ($urandom_range(0, 5))
        0:       len = 1;
        1:       len = $urandom_range(2, 19);
        2:       len = 21;
        3:       len = $urandom_range(22, 45);
        default: len = $urandom_range(1, 45);
      endcase
      if (text.size() > len) text = text[0:len-1];
      while (text.size() < len)
        text.push_back($urandom_range(0, 1) ? ChZ : CharW'($urandom_range(0, 255)));
      sent += len;
      send_text();
    end
  endtask

  // Test sequence
  initial begin
    rst_ni             = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_char();
    test_max_timestamp();
    wait_idle();
    test_calendar();
    wait_idle();
    test_corrupted();
    test_lengths();
    wait_idle();
    repeat (6) @(posedge clk_i);

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
